### hdl/hft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_pkg
// shared types and constants of the huffman tree node table
// ----------------------------------------------------------------------------
package hft_pkg;

    localparam int IDX_BITS     = 9;   // node index width on the ports
    localparam int SYM_IN_BITS  = 8;   // symbol width on the ports
    localparam int BYTE_BITS    = 8;   // coded bits per decode item
    localparam int MAX_CODE_LEN = 32;  // longest code the walk accepts
    localparam int CODE_W       = 32;  // code value width
    localparam int LEN_W        = 6;   // code length width
    localparam int USED_W       = 4;   // bits-used width

    typedef enum logic [1:0] {
        OP_ADD_LEAF = 2'd0,
        OP_ADD_NODE = 2'd1,
        OP_GET_CODE = 2'd2,
        OP_DECODE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [SYM_IN_BITS-1:0] symbol;
        logic [IDX_BITS-1:0]    left_index;
        logic [IDX_BITS-1:0]    right_index;
        logic [IDX_BITS-1:0]    node_index;
        logic [BYTE_BITS-1:0]   code_byte;
    } cmd_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] new_position;
        logic [CODE_W-1:0]   code_value;
        logic [LEN_W-1:0]    code_length;
        logic [USED_W-1:0]   bits_used;
        logic [IDX_BITS-1:0] end_position;
        logic                end_is_leaf;
        status_t             status;
    } result_t;

endpackage
`default_nettype wire

### hdl/huffman_tree_node_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_node_table_unit
// huffman code tree kept as a node table, with append, code and decode walks
// ----------------------------------------------------------------------------
// The tree lives in two synchronous memories with registered read data: a
// node memory (leaf mark, two child links, symbol) read by the decode walk,
// and a link memory (left-child mark, parent-valid, parent link) read by the
// code walk. One item is worked on at a time; the walks follow one link per
// cycle because each read address comes straight from the previous read's
// data. Appending an internal node makes one link-memory write per cycle,
// for the new node, then its left child, then its right child. A finished
// item sits in the output register so the next item is accepted while the
// result waits. Indices at or above the node count give status 1, appends to
// a full table status 2, code paths longer than 32 links status 3; on an
// error every other field is zero. There is no clearing pass: a node is only
// read after it was appended.
module huffman_tree_node_table_unit #(
    parameter int MAX_NODES   = 512,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // symbol, left_index, right_index, node_index, code_byte
    input  wire logic [1:0]  s_tuser,  // opcode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // new_position, code_value, code_length, bits_used,
                                       // end_position, end_is_leaf
    output logic [1:0]       m_tuser   // status
);

    import hft_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int NODE_W = 1 + 2 * IDX_W + SYMBOL_BITS;
    localparam int LINK_W = 2 + IDX_W;

    cmd_t    cmd;
    result_t res;
    logic    res_valid, res_ready;

    logic              node_we, link_we;
    logic [IDX_W-1:0]  node_waddr, link_waddr, rd_addr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic [LINK_W-1:0] link_wdata, link_rdata;

    logic    m_valid_reg;
    result_t m_data_reg;

    // unpack the input item
    assign cmd.opcode      = opcode_t'(s_tuser);
    assign cmd.symbol      = s_tdata[7:0];
    assign cmd.left_index  = s_tdata[16:8];
    assign cmd.right_index = s_tdata[25:17];
    assign cmd.node_index  = s_tdata[34:26];
    assign cmd.code_byte   = s_tdata[42:35];

    hft_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (cmd),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_rdata (node_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .rd_addr    (rd_addr),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // node memory: leaf mark, left child, right child, symbol
    hft_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (NODE_W)
    ) u_node_mem (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (rd_addr),
        .rdata (node_rdata)
    );

    // link memory: left-child mark, parent valid, parent
    hft_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (LINK_W)
    ) u_link_mem (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // output register, refilled as soon as it drains
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000,
                       m_data_reg.end_is_leaf,
                       m_data_reg.end_position,
                       m_data_reg.bits_used,
                       m_data_reg.code_length,
                       m_data_reg.code_value,
                       m_data_reg.new_position};
    assign m_tuser  = m_data_reg.status;

    // an error result carries nothing but its status
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_data_reg.status != ST_OK |-> m_tdata == 64'd0)
        else $error("error result with nonzero fields");

    // code walk never reports more than the longest code
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_data_reg.code_length <= LEN_W'(MAX_CODE_LEN))
        else $error("code length above limit");

    // a decode walk that stopped early stopped on a leaf
    a_decode_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_data_reg.status == ST_OK && m_data_reg.bits_used != '0
        && m_data_reg.bits_used != USED_W'(BYTE_BITS) |-> m_data_reg.end_is_leaf)
        else $error("decode walk stopped early on an internal node");

    // the sequencer is busy in the cycle after it accepts an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

endmodule
`default_nettype wire

### hdl/hft_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_ram
// single-port-write, single-port-read memory with registered read data
// ----------------------------------------------------------------------------
module hft_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/hft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_ctrl
// sequencer: appends nodes, relinks children, walks links one read per cycle
// ----------------------------------------------------------------------------
module hft_ctrl #(
    parameter int MAX_NODES   = 512,
    parameter int SYMBOL_BITS = 8,
    localparam int IDX_W  = $clog2(MAX_NODES),
    localparam int CNT_W  = $clog2(MAX_NODES + 1),
    localparam int NODE_W = 1 + 2 * IDX_W + SYMBOL_BITS,
    localparam int LINK_W = 2 + IDX_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire hft_pkg::cmd_t     cmd,
    output logic                   node_we,
    output logic [IDX_W-1:0]       node_waddr,
    output logic [NODE_W-1:0]      node_wdata,
    input  wire logic [NODE_W-1:0] node_rdata,
    output logic                   link_we,
    output logic [IDX_W-1:0]       link_waddr,
    output logic [LINK_W-1:0]      link_wdata,
    input  wire logic [LINK_W-1:0] link_rdata,
    output logic [IDX_W-1:0]       rd_addr,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output hft_pkg::result_t       res
);

    import hft_pkg::*;

    localparam int CMP_W = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK_L,
        S_LINK_R,
        S_CODE,
        S_DEC,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     left_reg, left_next;
    logic [IDX_W-1:0]     right_reg, right_next;
    logic [IDX_W-1:0]     par_reg, par_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [CODE_W-1:0]    val_reg, val_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    result_t              res_reg, res_next;

    // fields of the entries being read
    logic             lk_left, lk_has;
    logic [IDX_W-1:0] lk_par;
    logic             nd_leaf;
    logic [IDX_W-1:0] nd_kl, nd_kr, nd_nxt;

    logic table_full, li_bad, ri_bad, ni_bad, par_bad, nxt_bad;

    assign lk_left = link_rdata[IDX_W+1];
    assign lk_has  = link_rdata[IDX_W];
    assign lk_par  = link_rdata[IDX_W-1:0];
    assign nd_leaf = node_rdata[NODE_W-1];
    assign nd_kl   = node_rdata[NODE_W-2 -: IDX_W];
    assign nd_kr   = node_rdata[SYMBOL_BITS +: IDX_W];
    assign nd_nxt  = byte_reg[BYTE_BITS-1] ? nd_kl : nd_kr;

    assign table_full = (count_reg == CNT_W'(MAX_NODES));
    assign li_bad  = CMP_W'(cmd.left_index)  >= CMP_W'(count_reg);
    assign ri_bad  = CMP_W'(cmd.right_index) >= CMP_W'(count_reg);
    assign ni_bad  = CMP_W'(cmd.node_index)  >= CMP_W'(count_reg);
    assign par_bad = CMP_W'(lk_par) >= CMP_W'(count_reg);
    assign nxt_bad = CMP_W'(nd_nxt) >= CMP_W'(count_reg);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        right_next = right_reg;
        par_next   = par_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        used_next  = used_reg;
        byte_next  = byte_reg;
        res_next   = res_reg;
        node_we    = 1'b0;
        node_waddr = count_reg[IDX_W-1:0];
        node_wdata = '0;
        link_we    = 1'b0;
        link_waddr = count_reg[IDX_W-1:0];
        link_wdata = '0;
        rd_addr    = IDX_W'(cmd.node_index);

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    res_next = '0;
                    case (cmd.opcode)
                        OP_ADD_LEAF: begin
                            state_next = S_DONE;
                            if (table_full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                node_we    = 1'b1;
                                node_wdata = {1'b1, {(2 * IDX_W){1'b0}},
                                              SYMBOL_BITS'(cmd.symbol)};
                                link_we    = 1'b1;
                                res_next.new_position = IDX_BITS'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_ADD_NODE: begin
                            if (li_bad || ri_bad) begin
                                res_next.status = ST_RANGE;
                                state_next = S_DONE;
                            end else if (table_full) begin
                                res_next.status = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                // new parent entry now, then the left and right child links in S_LINK_L and S_LINK_R
                                node_we    = 1'b1;
                                node_wdata = {1'b0, IDX_W'(cmd.left_index),
                                              IDX_W'(cmd.right_index),
                                              {SYMBOL_BITS{1'b0}}};
                                link_we    = 1'b1;
                                left_next  = IDX_W'(cmd.left_index);
                                right_next = IDX_W'(cmd.right_index);
                                par_next   = count_reg[IDX_W-1:0];
                                res_next.new_position = IDX_BITS'(count_reg);
                                count_next = count_reg + 1'b1;
                                state_next = S_LINK_L;
                            end
                        end
                        OP_GET_CODE, OP_DECODE: begin
                            if (ni_bad) begin
                                res_next.status = ST_RANGE;
                                state_next = S_DONE;
                            end else begin
                                pos_next   = IDX_W'(cmd.node_index);
                                len_next   = '0;
                                val_next   = '0;
                                used_next  = '0;
                                byte_next  = cmd.code_byte;
                                state_next = (cmd.opcode == OP_GET_CODE) ? S_CODE : S_DEC;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LINK_L: begin
                link_we    = 1'b1;
                link_waddr = left_reg;
                link_wdata = {1'b1, 1'b1, par_reg};
                state_next = S_LINK_R;
            end
            S_LINK_R: begin
                // right written last so a node used twice ends as a right child
                link_we    = 1'b1;
                link_waddr = right_reg;
                link_wdata = {1'b0, 1'b1, par_reg};
                state_next = S_DONE;
            end
            S_CODE: begin
                rd_addr = lk_par;
                if (!lk_has) begin
                    res_next.code_value  = val_reg;
                    res_next.code_length = len_reg;
                    state_next = S_DONE;
                end else if (len_reg >= LEN_W'(MAX_CODE_LEN)) begin
                    res_next.status = ST_LONG;
                    state_next = S_DONE;
                end else if (par_bad) begin
                    res_next.status = ST_RANGE;
                    state_next = S_DONE;
                end else begin
                    if (lk_left) begin
                        val_next = val_reg | (CODE_W'(1) << len_reg);
                    end
                    len_next = len_reg + 1'b1;
                    pos_next = lk_par;
                end
            end
            S_DEC: begin
                rd_addr = nd_nxt;
                if (used_reg == USED_W'(BYTE_BITS) || nd_leaf) begin
                    res_next.bits_used    = used_reg;
                    res_next.end_position = IDX_BITS'(pos_reg);
                    res_next.end_is_leaf  = nd_leaf;
                    state_next = S_DONE;
                end else if (nxt_bad) begin
                    res_next.status = ST_RANGE;
                    state_next = S_DONE;
                end else begin
                    pos_next  = nd_nxt;
                    used_next = used_reg + 1'b1;
                    byte_next = {byte_reg[BYTE_BITS-2:0], 1'b0};
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        par_reg   <= par_next;
        len_reg   <= len_next;
        val_reg   <= val_next;
        used_reg  <= used_next;
        byte_reg  <= byte_next;
        res_reg   <= res_next;
    end

endmodule
`default_nettype wire

### tb/tb_huffman_tree_node_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_huffman_tree_node_table_unit
// self-checking bench for the huffman tree node table
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of the node table, predicts the result
// of every item taken on the input stream and checks every result item in
// order. Stimulus is a short directed run over the special cases (empty
// table, roots, leaves, same child twice, re-parenting, bad indices),
// followed by random tree building: leaves, merges of roots, deep chains
// that run past the code length limit, code and decode queries, noise, and
// finally appends to a full table. Sender gaps and receiver stalls change
// from phase to phase, with one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_huffman_tree_node_table_unit;

    import hft_pkg::*;

    localparam int TABLE_SIZE  = 512;   // default node table depth of the block
    localparam int STALL_LIMIT = 4000;  // quiet cycles before the run is abandoned
    localparam int DRAIN_WAIT  = 40;    // longest walk plus output register
    localparam int RANDOM_ITEMS = 700;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;     // symbol, left_index, right_index, node_index, code_byte
    logic [1:0]  s_tuser  = '0;     // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // new_position, code_value, code_length, bits_used,
                                    // end_position, end_is_leaf
    logic [1:0]  m_tuser;           // status

    // idling controls, read by the driver and the receiver
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_off_left = 0;

    always #4 aclk = ~aclk;

    huffman_tree_node_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // tracker: own copy of the node table and the queue of predicted results
    // ------------------------------------------------------------------------
    class node_table_tracker;
        bit                      is_leaf   [TABLE_SIZE];
        bit                      on_left   [TABLE_SIZE];
        bit                      linked    [TABLE_SIZE];
        logic [IDX_BITS-1:0]     up_link   [TABLE_SIZE];
        logic [IDX_BITS-1:0]     left_kid  [TABLE_SIZE];
        logic [IDX_BITS-1:0]     right_kid [TABLE_SIZE];
        logic [SYM_IN_BITS-1:0]  sym_bits  [TABLE_SIZE];
        int unsigned             count;
        result_t                 pending [$];
        int unsigned             errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function result_t predict(cmd_t c);
            result_t     r;
            int unsigned pos;
            int unsigned steps;
            int unsigned p;
            logic [CODE_W-1:0] val;
            r   = '0;
            val = '0;
            case (c.opcode)
                OP_ADD_LEAF: begin
                    if (count >= TABLE_SIZE) begin
                        r.status = ST_FULL;
                    end else begin
                        is_leaf[count]   = 1'b1;
                        on_left[count]   = 1'b0;
                        linked[count]    = 1'b0;
                        up_link[count]   = '0;
                        left_kid[count]  = '0;
                        right_kid[count] = '0;
                        sym_bits[count]  = c.symbol;
                        r.new_position   = count[IDX_BITS-1:0];
                        count++;
                    end
                end
                OP_ADD_NODE: begin
                    // index check ahead of the full check
                    if (c.left_index >= count || c.right_index >= count) begin
                        r.status = ST_RANGE;
                    end else if (count >= TABLE_SIZE) begin
                        r.status = ST_FULL;
                    end else begin
                        p = count;
                        is_leaf[p]   = 1'b0;
                        on_left[p]   = 1'b0;
                        linked[p]    = 1'b0;
                        up_link[p]   = '0;
                        left_kid[p]  = c.left_index;
                        right_kid[p] = c.right_index;
                        sym_bits[p]  = '0;
                        on_left[c.left_index]  = 1'b1;
                        linked[c.left_index]   = 1'b1;
                        up_link[c.left_index]  = p[IDX_BITS-1:0];
                        // right link written last: same child twice ends up right
                        on_left[c.right_index] = 1'b0;
                        linked[c.right_index]  = 1'b1;
                        up_link[c.right_index] = p[IDX_BITS-1:0];
                        count++;
                        r.new_position = p[IDX_BITS-1:0];
                    end
                end
                default: begin
                    if (c.node_index >= count) begin
                        r.status = ST_RANGE;
                    end else if (c.opcode == OP_GET_CODE) begin
                        pos   = c.node_index;
                        steps = 0;
                        while (linked[pos]) begin
                            if (steps >= MAX_CODE_LEN) begin
                                r.status = ST_LONG;
                                break;
                            end
                            if (on_left[pos]) val[steps] = 1'b1;
                            steps++;
                            pos = up_link[pos];
                            if (pos >= count) begin
                                r.status = ST_RANGE;
                                break;
                            end
                        end
                        if (r.status == ST_OK) begin
                            r.code_value  = val;
                            r.code_length = steps[LEN_W-1:0];
                        end
                    end else begin
                        pos   = c.node_index;
                        steps = 0;
                        while (steps < BYTE_BITS && !is_leaf[pos]) begin
                            pos = c.code_byte[BYTE_BITS-1-steps] ? left_kid[pos] : right_kid[pos];
                            steps++;
                        end
                        r.bits_used    = steps[USED_W-1:0];
                        r.end_position = pos[IDX_BITS-1:0];
                        r.end_is_leaf  = is_leaf[pos];
                    end
                end
            endcase
            return r;
        endfunction

        function void note_item(cmd_t c);
            pending = {pending, predict(c)};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("result item with no prediction pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("new_position", 64'(want.new_position), 64'(got.new_position));
            compare_field("code_value",   64'(want.code_value),   64'(got.code_value));
            compare_field("code_length",  64'(want.code_length),  64'(got.code_length));
            compare_field("bits_used",    64'(want.bits_used),    64'(got.bits_used));
            compare_field("end_position", 64'(want.end_position), 64'(got.end_position));
            compare_field("end_is_leaf",  64'(want.end_is_leaf),  64'(got.end_is_leaf));
            compare_field("status",       64'(want.status),       64'(got.status));
        endfunction
    endclass

    node_table_tracker tracker = new();

    // ------------------------------------------------------------------------
    // monitors: both sides sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cmd_t    seen_cmd;
        result_t seen_res;
        if (aresetn && s_tvalid && s_tready) begin
            seen_cmd.opcode      = opcode_t'(s_tuser);
            seen_cmd.symbol      = s_tdata[7:0];
            seen_cmd.left_index  = s_tdata[16:8];
            seen_cmd.right_index = s_tdata[25:17];
            seen_cmd.node_index  = s_tdata[34:26];
            seen_cmd.code_byte   = s_tdata[42:35];
            tracker.note_item(seen_cmd);
        end
        if (aresetn && m_tvalid && m_tready) begin
            seen_res.new_position = m_tdata[8:0];
            seen_res.code_value   = m_tdata[40:9];
            seen_res.code_length  = m_tdata[46:41];
            seen_res.bits_used    = m_tdata[50:47];
            seen_res.end_position = m_tdata[59:51];
            seen_res.end_is_leaf  = m_tdata[60];
            seen_res.status       = status_t'(m_tuser);
            tracker.check_result(seen_res);
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog: ends the run when no item moves on either side for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("** huffman_tree_node_table_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver and item generation
    // ------------------------------------------------------------------------
    int unsigned gen_count = 0;     // nodes the table will hold once all sent items land
    int unsigned live_roots [$];    // nodes believed to have no parent
    int unsigned deep_leaves [$];   // bottoms of long chains
    int unsigned items_sent = 0;

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, c.code_byte, c.node_index, c.right_index, c.left_index, c.symbol};
        s_tuser  <= c.opcode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.opcode      = opcode_t'($urandom_range(3));
        c.symbol      = SYM_IN_BITS'($urandom_range(255));
        c.left_index  = IDX_BITS'($urandom_range(511));
        c.right_index = IDX_BITS'($urandom_range(511));
        c.node_index  = IDX_BITS'($urandom_range(511));
        c.code_byte   = BYTE_BITS'($urandom_range(255));
        return c;
    endfunction

    function automatic void drop_root(int unsigned idx);
        for (int i = live_roots.size() - 1; i >= 0; i--)
            if (live_roots[i] == idx) live_roots.delete(i);
    endfunction

    // keeps the generator's view of the table in step, then drives the item
    task automatic issue(input cmd_t c);
        if (c.opcode == OP_ADD_LEAF) begin
            if (gen_count < TABLE_SIZE) begin
                live_roots = {live_roots, gen_count};
                gen_count++;
            end
        end else if (c.opcode == OP_ADD_NODE) begin
            if (c.left_index < gen_count && c.right_index < gen_count &&
                gen_count < TABLE_SIZE) begin
                drop_root(c.left_index);
                drop_root(c.right_index);
                live_roots = {live_roots, gen_count};
                gen_count++;
            end
        end
        send_cmd(c);
    endtask

    task automatic add_leaf(input logic [7:0] sym);
        cmd_t c;
        c        = random_cmd();
        c.opcode = OP_ADD_LEAF;
        c.symbol = sym;
        issue(c);
    endtask

    task automatic join_nodes(input logic [8:0] li, input logic [8:0] ri);
        cmd_t c;
        c             = random_cmd();
        c.opcode      = OP_ADD_NODE;
        c.left_index  = li;
        c.right_index = ri;
        issue(c);
    endtask

    task automatic ask_code(input logic [8:0] ni);
        cmd_t c;
        c            = random_cmd();
        c.opcode     = OP_GET_CODE;
        c.node_index = ni;
        issue(c);
    endtask

    task automatic walk_down(input logic [8:0] ni, input logic [7:0] cb);
        cmd_t c;
        c            = random_cmd();
        c.opcode     = OP_DECODE;
        c.node_index = ni;
        c.code_byte  = cb;
        issue(c);
    endtask

    function automatic int unsigned pick_node();
        if (gen_count == 0) return $urandom_range(511);
        return $urandom_range(gen_count - 1);
    endfunction

    // a chain of depth internal nodes, each over the previous one and a fresh
    // leaf; the bottom leaf's path is depth links long
    task automatic build_chain(input int unsigned depth);
        int unsigned bottom;
        int unsigned prev;
        int unsigned leaf_at;
        bit          steer [$];
        logic [7:0]  cb;
        bottom = gen_count;
        add_leaf(SYM_IN_BITS'($urandom_range(255)));
        prev = bottom;
        for (int unsigned k = 0; k < depth; k++) begin
            leaf_at = gen_count;
            add_leaf(SYM_IN_BITS'($urandom_range(255)));
            if ($urandom_range(1)) begin
                join_nodes(IDX_BITS'(prev), IDX_BITS'(leaf_at));
                steer = {steer, 1'b1};
            end else begin
                join_nodes(IDX_BITS'(leaf_at), IDX_BITS'(prev));
                steer = {steer, 1'b0};
            end
            prev = gen_count - 1;
        end
        deep_leaves = {deep_leaves, bottom};
        ask_code(IDX_BITS'(bottom));
        // steer down the chain so that all eight bits land on internal nodes
        for (int k = 0; k < 8; k++) cb[7-k] = steer[depth-1-k];
        if ($urandom_range(3) == 0) cb = BYTE_BITS'($urandom_range(255));
        walk_down(IDX_BITS'(prev), cb);
    endtask

    task automatic merge_roots();
        int unsigned a;
        int unsigned b;
        if (live_roots.size() < 2) begin
            add_leaf(SYM_IN_BITS'($urandom_range(255)));
        end else begin
            a = $urandom_range(live_roots.size() - 1);
            b = $urandom_range(live_roots.size() - 2);
            if (b >= a) b++;
            join_nodes(IDX_BITS'(live_roots[a]), IDX_BITS'(live_roots[b]));
        end
    endtask

    task automatic set_idling(input int unsigned phase);
        case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pick;
        int unsigned phase;
        int unsigned last_phase;
        int unsigned chains_built;
        int unsigned depth;
        int unsigned base_items;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, tiny tree, same child twice, re-parenting
        ask_code(9'd0);                 // nothing appended yet
        walk_down(9'd0, 8'hFF);
        join_nodes(9'd0, 9'd0);
        add_leaf(8'h00);                // node 0
        add_leaf(8'hFF);                // node 1
        add_leaf(8'h5A);                // node 2
        ask_code(9'd0);                 // root: empty code
        walk_down(9'd0, 8'h00);         // starts on a leaf
        join_nodes(9'd0, 9'd1);         // node 3
        ask_code(9'd0);
        ask_code(9'd1);
        walk_down(9'd3, 8'hFF);
        walk_down(9'd3, 8'h00);
        join_nodes(9'd3, 9'd2);         // node 4
        ask_code(9'd0);
        walk_down(9'd4, 8'h80);
        join_nodes(9'd2, 9'd2);         // node 5, same child on both sides
        ask_code(9'd2);
        join_nodes(9'd4, 9'd0);         // node 6, node 0 taken from node 3
        ask_code(9'd0);
        ask_code(9'd3);
        join_nodes(9'd0, 9'd511);
        join_nodes(9'd511, 9'd0);
        ask_code(9'd511);
        walk_down(9'd511, 8'hFF);
        walk_down(9'd5, 8'h00);

        // random tree building, four idling phases
        base_items   = items_sent;
        last_phase   = 0;
        chains_built = 0;
        set_idling(0);
        while (items_sent - base_items < RANDOM_ITEMS || gen_count < TABLE_SIZE) begin
            phase = ((items_sent - base_items) * 4) / RANDOM_ITEMS;
            if (phase > 3) phase = 3;
            if (phase != last_phase) begin
                if (phase == 2) begin
                    // drain completely, then a long hold-off while items keep coming
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (tracker.pending.size() != 0) @(posedge aclk);
                    hold_off_left = 250;
                end
                set_idling(phase);
                last_phase = phase;
            end

            pick = $urandom_range(99);
            case (chains_built)
                0: depth = 33;
                1: depth = 32;
                default: depth = $urandom_range(28, 38);
            endcase
            if (pick < 3 && chains_built < 3 && gen_count + 2 * depth + 1 <= TABLE_SIZE) begin
                build_chain(depth);
                chains_built++;
            end else if (pick < 40) begin
                merge_roots();
            end else if (pick < 60) begin
                add_leaf(SYM_IN_BITS'($urandom_range(255)));
            end else if (pick < 72) begin
                if (deep_leaves.size() != 0 && $urandom_range(2) == 0)
                    ask_code(IDX_BITS'(deep_leaves[$urandom_range(deep_leaves.size() - 1)]));
                else
                    ask_code(IDX_BITS'(pick_node()));
            end else if (pick < 85) begin
                if (live_roots.size() != 0 && $urandom_range(1))
                    walk_down(IDX_BITS'(live_roots[$urandom_range(live_roots.size() - 1)]),
                              BYTE_BITS'($urandom_range(255)));
                else
                    walk_down(IDX_BITS'(pick_node()), BYTE_BITS'($urandom_range(255)));
            end else begin
                issue(random_cmd());    // noise, mostly bad indices early on
            end
        end

        // table is full now: both appends refused, walks still served
        add_leaf(SYM_IN_BITS'($urandom_range(255)));
        join_nodes(9'd0, 9'd511);
        ask_code(9'd0);
        walk_down(9'd511, BYTE_BITS'($urandom_range(255)));

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("** huffman_tree_node_table_unit: PASSED **");
        end else begin
            $display("** huffman_tree_node_table_unit: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
